>>> design/swdc_pkg.sv
package swdc_pkg;

    // Default width of the step timer
    localparam int COUNTER_WIDTH_DEFAULT = 16;

    // Delay register bank
    localparam int NUM_DELAYS  = 4;
    localparam int DELAY_WIDTH = 16;
    localparam int SPEED_WIDTH = $clog2(NUM_DELAYS);

    // APB port geometry: one 32-bit word per register
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = SPEED_WIDTH + 2;

    // Register indexes
    localparam logic [SPEED_WIDTH-1:0] REG_DELAY_SPEED0 = 2'd0;
    localparam logic [SPEED_WIDTH-1:0] REG_DELAY_SPEED1 = 2'd1;
    localparam logic [SPEED_WIDTH-1:0] REG_DELAY_SPEED2 = 2'd2;
    localparam logic [SPEED_WIDTH-1:0] REG_DELAY_SPEED3 = 2'd3;

    // Reset values of the delay registers
    localparam logic [DELAY_WIDTH-1:0] DELAY_SPEED0_RESET = 16'd6249;
    localparam logic [DELAY_WIDTH-1:0] DELAY_SPEED1_RESET = 16'd3124;
    localparam logic [DELAY_WIDTH-1:0] DELAY_SPEED2_RESET = 16'd1562;
    localparam logic [DELAY_WIDTH-1:0] DELAY_SPEED3_RESET = 16'd780;

    // Request kinds carried in req_type
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_BUTTONS = 1'b1;

    // Button bit positions (active low)
    localparam int BTN_RUN   = 0;
    localparam int BTN_DIR   = 1;
    localparam int BTN_SPEED = 2;

    // All buttons released
    localparam logic [2:0] BUTTONS_RELEASED = 3'b111;

    typedef logic [NUM_DELAYS-1:0][DELAY_WIDTH-1:0] delay_bank_t;

    typedef struct packed {
        logic       req_type;
        logic [2:0] button_levels;
    } item_t;

    typedef struct packed {
        logic [3:0] coil_drive;
        logic       step_fired;
        logic       step_indicator;
        logic       press_indicator;
    } result_t;

endpackage

>>> design/stepper_wave_drive_controller.sv
// Four-phase stepper wave-drive controller. Each input beat is either one
// prescaled timer tick (req_type 0) or a sample of the three active-low
// buttons (req_type 1: run/stop, direction, speed), and every input beat
// yields exactly one result beat carrying the coil outputs, a step-fired
// flag and the two indicator levels. A new beat is accepted on every clock
// while item_ready is high, and its result is registered for output. The
// output register is backed by a skid register, so input keeps flowing for
// one beat while a result waits, and item_ready drops only when both are
// occupied. The step timer is COUNTER_WIDTH bits wide and compares against
// the low COUNTER_WIDTH bits of the delay register of the current speed;
// when it matches, the timer wraps to zero and a step fires. While running,
// a step latches the one-hot coil pattern of the current phase and moves the
// phase forward or back by one; while stopped, a step switches all coils
// off. A speed press also restarts the timer. The four delay registers sit
// at APB byte addresses 0, 4, 8 and 12 and should only be written while the
// block is idle.
module stepper_wave_drive_controller #(
    parameter int COUNTER_WIDTH = swdc_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swdc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [swdc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [swdc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready,

    // Input beats: timer ticks and button samples
    input  logic                                item_valid,
    output logic                                item_ready,
    input  swdc_pkg::item_t                     item,

    // Result beats
    output logic                                result_valid,
    input  logic                                result_ready,
    output swdc_pkg::result_t                   result
);

    // Current contents of the delay registers, one per speed index.
    swdc_pkg::delay_bank_t delays;

    swdc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .delays  (delays)
    );

    // State update and result buffering; all work for a beat happens in the
    // cycle it is accepted.
    swdc_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .delays       (delays),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> design/swdc_apb_regs.sv
// Delay register bank behind an APB slave. Writes complete in the access
// phase; reads return the addressed register zero-extended.
module swdc_apb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swdc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [swdc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [swdc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    output swdc_pkg::delay_bank_t               delays
);

    swdc_pkg::delay_bank_t                delays_reg;
    logic [swdc_pkg::SPEED_WIDTH-1:0]     reg_index;
    logic                                 write_en;

    assign reg_index = paddr[swdc_pkg::APB_ADDR_WIDTH-1:2];
    assign write_en  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delays_reg[swdc_pkg::REG_DELAY_SPEED0] <= swdc_pkg::DELAY_SPEED0_RESET;
            delays_reg[swdc_pkg::REG_DELAY_SPEED1] <= swdc_pkg::DELAY_SPEED1_RESET;
            delays_reg[swdc_pkg::REG_DELAY_SPEED2] <= swdc_pkg::DELAY_SPEED2_RESET;
            delays_reg[swdc_pkg::REG_DELAY_SPEED3] <= swdc_pkg::DELAY_SPEED3_RESET;
        end
        else if (write_en)
        begin
            delays_reg[reg_index] <= pwdata[swdc_pkg::DELAY_WIDTH-1:0];
        end
    end

    assign prdata = swdc_pkg::APB_DATA_WIDTH'(delays_reg[reg_index]);
    assign delays = delays_reg;

endmodule

>>> design/swdc_core.sv
// Controller state, single-pass update per beat, and a two-entry result
// buffer (output register plus skid register).
module swdc_core #(
    parameter int COUNTER_WIDTH = swdc_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swdc_pkg::delay_bank_t delays,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  swdc_pkg::item_t       item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output swdc_pkg::result_t     result
);

    // Controller state
    logic [COUNTER_WIDTH-1:0]          tick_count_reg, tick_count_next;
    logic [swdc_pkg::SPEED_WIDTH-1:0]  speed_index_reg, speed_index_next;
    logic [1:0]                        phase_index_reg, phase_index_next;
    logic                              running_reg, running_next;
    logic                              forward_reg, forward_next;
    logic [2:0]                        prev_buttons_reg, prev_buttons_next;
    logic [3:0]                        coil_latch_reg, coil_latch_next;
    logic                              step_led_reg, step_led_next;
    logic                              press_led_reg, press_led_next;

    // Result buffer
    logic                              out_valid_reg, out_valid_next;
    logic                              skid_valid_reg, skid_valid_next;
    swdc_pkg::result_t                 out_data_reg, out_data_next;
    swdc_pkg::result_t                 skid_data_reg, skid_data_next;

    logic                              accept;
    logic                              out_free;
    logic [COUNTER_WIDTH-1:0]          limit;
    logic                              hit;
    logic [2:0]                        fell;
    swdc_pkg::result_t                 new_result;

    assign item_ready = !skid_valid_reg;
    assign accept     = item_valid && item_ready;
    assign out_free   = !out_valid_reg || result_ready;

    assign limit = COUNTER_WIDTH'(delays[speed_index_reg]);
    assign hit   = (tick_count_reg == limit);
    assign fell  = prev_buttons_reg & ~item.button_levels;

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        speed_index_next  = speed_index_reg;
        phase_index_next  = phase_index_reg;
        running_next      = running_reg;
        forward_next      = forward_reg;
        prev_buttons_next = prev_buttons_reg;
        coil_latch_next   = coil_latch_reg;
        step_led_next     = step_led_reg;
        press_led_next    = press_led_reg;
        new_result.step_fired = 1'b0;

        if (accept)
        begin
            if (item.req_type == swdc_pkg::REQ_TICK)
            begin
                if (hit)
                begin
                    tick_count_next       = '0;
                    new_result.step_fired = 1'b1;
                    step_led_next         = !step_led_reg;
                    if (running_reg)
                    begin
                        coil_latch_next  = 4'b0001 << phase_index_reg;
                        phase_index_next = forward_reg ? phase_index_reg + 2'd1
                                                       : phase_index_reg - 2'd1;
                    end
                    else
                    begin
                        coil_latch_next = '0;
                    end
                end
                else
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
            end
            else
            begin
                running_next   = running_reg ^ fell[swdc_pkg::BTN_RUN];
                forward_next   = forward_reg ^ fell[swdc_pkg::BTN_DIR];
                press_led_next = press_led_reg ^ (^fell);
                if (fell[swdc_pkg::BTN_SPEED])
                begin
                    speed_index_next = speed_index_reg + 1'b1;
                    tick_count_next  = '0;
                end
                prev_buttons_next = item.button_levels;
            end
        end

        new_result.coil_drive      = coil_latch_next;
        new_result.step_indicator  = step_led_next;
        new_result.press_indicator = press_led_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || accept;
            out_data_next   = skid_valid_reg ? skid_data_reg : new_result;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = new_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            speed_index_reg  <= '0;
            phase_index_reg  <= '0;
            running_reg      <= 1'b1;
            forward_reg      <= 1'b0;
            prev_buttons_reg <= swdc_pkg::BUTTONS_RELEASED;
            coil_latch_reg   <= '0;
            step_led_reg     <= 1'b0;
            press_led_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            tick_count_reg   <= tick_count_next;
            speed_index_reg  <= speed_index_next;
            phase_index_reg  <= phase_index_next;
            running_reg      <= running_next;
            forward_reg      <= forward_next;
            prev_buttons_reg <= prev_buttons_next;
            coil_latch_reg   <= coil_latch_next;
            step_led_reg     <= step_led_next;
            press_led_reg    <= press_led_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // The skid register is only ever filled behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while output register is empty");

    // The coil latch is a one-hot phase pattern or all off.
    a_coil_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(coil_latch_reg))
        else $error("coil latch drives more than one coil");

    // A speed-button press restarts the step timer.
    a_speed_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.req_type == swdc_pkg::REQ_BUTTONS) && fell[swdc_pkg::BTN_SPEED]
        |=> (tick_count_reg == '0))
        else $error("speed change did not clear the step timer");

    // An accepted beat always leaves a result pending in the next cycle.
    a_accept_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

endmodule
